// ===== rtl/bdm_pkg.sv =====
// Shared types and constants of the 2x2 Bayer demosaic block.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package bdm_pkg;

  // Line store depth default, in pixels.
  localparam int MAX_WIDTH_DEF = 2048;

  // Entries of the window queue between front and back; a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BAYER_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0]  BAYER_ORDER_RST  = 2'd0;
  localparam logic [11:0] ROW_WIDTH_RST    = 12'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

  // Row and column parity of red in row 0 for RGGB, BGGR, GBRG, GRBG.
  localparam logic [3:0] RED_ROW = 4'b0110;
  localparam logic [3:0] RED_COL = 4'b1010;

  typedef struct packed {
    logic [1:0]  bayer_order;
    logic [11:0] row_width;
    logic [15:0] frame_height;
  } bdm_cfg_t;

  // One 2x2 window: top-left, top-right, bottom-left, bottom-right.
  typedef struct packed {
    logic [7:0] q0;
    logic [7:0] q1;
    logic [7:0] q2;
    logic [7:0] q3;
    logic       tp;    // row parity of the top-left sample
    logic       lp;    // column parity of the top-left sample
    logic       two;   // row end: emit twice, second with end of row
    logic       last;  // last replayed pixel of the frame
  } bdm_entry_t;

  // Position of red within the window.
  function automatic logic [1:0] red_index(input logic [1:0] order,
                                           input logic tp, input logic lp);
    red_index = {RED_ROW[order] ^ tp, RED_COL[order] ^ lp};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bdm_line_store.sv =====
// One row of raw samples: one write port, two registered read ports.
// Depends on bdm_pkg for the default depth.
`default_nettype none

module bdm_line_store #(
  parameter int DEPTH = bdm_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [7:0]    rdata_a,
  output logic      [7:0]    rdata_b
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/bdm_front.sv =====
// Front end: accepts raw and flush items, keeps the raster counters, drives
// the two line stores and forms 2x2 windows. Depends on bdm_pkg, bdm_line_store.
`default_nettype none

module bdm_front #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bdm_pkg::bdm_cfg_t      cfg,
  input  wire logic                   in_valid,
  input  wire logic                   in_op,
  input  wire logic [7:0]             in_raw_pixel,
  output logic                        in_stall,
  input  wire logic [bdm_pkg::QCW-1:0] q_count,
  output logic                        push,
  output bdm_pkg::bdm_entry_t         push_entry
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int TOP = (MAX_WIDTH / 2) * 2;

  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] rep_r, rep_nxt;

  logic [11:0] rw_even;
  logic [31:0] w32;
  logic [15:0] fh_even, heff;
  logic        in_replay, col_last, rep_last, acc, is_norm, is_rep;
  logic [CW-1:0] left, left_b, raddr_a;

  logic [7:0] up_rd_a, up_rd_b, lo_rd_a, lo_rd_b, above;

  logic       s1_valid_r, s1_rep_r, s1_emit_r, s1_two_r, s1_last_r;
  logic       s1_odd_r, s1_tp_r, s1_lp_r;
  logic [7:0] s1_pix_r;
  logic [15:0] prev_r;

  always_comb begin
    rw_even = {cfg.row_width[11:1], 1'b0};
    w32 = {20'd0, rw_even};
    if (w32 < 32'd2) begin
      w32 = 32'd2;
    end else if (w32 > 32'(TOP)) begin
      w32 = 32'(TOP);
    end
    fh_even = {cfg.frame_height[15:1], 1'b0};
    heff = (fh_even < 16'd2) ? 16'd2 : fh_even;
  end

  assign in_replay = (row_r >= heff);
  assign col_last  = ((32'(col_r) + 32'd1) >= w32);
  assign rep_last  = ((32'(rep_r) + 32'd1) >= w32);
  assign left      = rep_last ? CW'(w32 - 32'd2) : rep_r;
  assign left_b    = left + CW'(1);
  assign raddr_a   = in_replay ? left : col_r;

  // Hold off while the queue has no room for an item in flight.
  assign in_stall = ((32'(q_count) + 32'(s1_valid_r)) >= 32'(bdm_pkg::QDEPTH));
  assign acc      = in_valid && !in_stall;
  assign is_norm  = acc && !in_replay && !in_op;
  assign is_rep   = acc && in_replay && in_op;

  bdm_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .we      (is_norm && !row_r[0]),
    .waddr   (col_r),
    .wdata   (in_raw_pixel),
    .raddr_a (raddr_a),
    .raddr_b (left_b),
    .rdata_a (up_rd_a),
    .rdata_b (up_rd_b)
  );

  bdm_line_store #(.DEPTH(MAX_WIDTH)) u_lower (
    .clk     (clk),
    .we      (is_norm && row_r[0]),
    .waddr   (col_r),
    .wdata   (in_raw_pixel),
    .raddr_a (raddr_a),
    .raddr_b (left_b),
    .rdata_a (lo_rd_a),
    .rdata_b (lo_rd_b)
  );

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    rep_nxt = rep_r;
    if (is_rep) begin
      if (rep_last) begin
        col_nxt = '0;
        row_nxt = '0;
        rep_nxt = '0;
      end else begin
        rep_nxt = rep_r + CW'(1);
      end
    end else if (is_norm) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + 16'd1;
        if ((row_r + 16'd1) >= heff) begin
          rep_nxt = '0;
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      rep_r      <= '0;
      s1_valid_r <= 1'b0;
      prev_r     <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      rep_r      <= rep_nxt;
      s1_valid_r <= is_norm || is_rep;
      if (s1_valid_r && !s1_rep_r) begin
        prev_r <= {above, s1_pix_r};
      end
    end
  end

  // Window bookkeeping is registered like the store reads so that it meets their read data.
  always_ff @(posedge clk) begin
    s1_rep_r  <= is_rep;
    s1_emit_r <= (row_r != 16'd0) && (col_r != '0);
    s1_two_r  <= col_last && !in_replay;
    s1_last_r <= rep_last;
    s1_odd_r  <= row_r[0];
    s1_tp_r   <= in_replay ? 1'b0 : !row_r[0];
    s1_lp_r   <= in_replay ? left[0] : !col_r[0];
    s1_pix_r  <= in_raw_pixel;
  end

  // The row above lives in the store not written by the current row.
  assign above = s1_odd_r ? up_rd_a : lo_rd_a;
  assign push  = s1_valid_r && (s1_rep_r || s1_emit_r);

  always_comb begin
    push_entry.tp = s1_tp_r;
    push_entry.lp = s1_lp_r;
    if (s1_rep_r) begin
      push_entry.q0   = up_rd_a;
      push_entry.q1   = up_rd_b;
      push_entry.q2   = lo_rd_a;
      push_entry.q3   = lo_rd_b;
      push_entry.two  = 1'b0;
      push_entry.last = s1_last_r;
    end else begin
      push_entry.q0   = prev_r[15:8];
      push_entry.q1   = above;
      push_entry.q2   = prev_r[7:0];
      push_entry.q3   = s1_pix_r;
      push_entry.two  = s1_two_r;
      push_entry.last = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdm_queue.sv =====
// Short FIFO of 2x2 windows between the front and the back end.
// Depends on bdm_pkg for the entry type and depth.
`default_nettype none

module bdm_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire bdm_pkg::bdm_entry_t     push_entry,
  input  wire logic                    pop,
  output logic                         head_valid,
  output bdm_pkg::bdm_entry_t          head,
  output logic [bdm_pkg::QCW-1:0]      count
);

  bdm_pkg::bdm_entry_t slots_r [bdm_pkg::QDEPTH];
  logic [bdm_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [bdm_pkg::QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + bdm_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bdm_pkg::QAW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + bdm_pkg::QCW'(1);
        2'b01:   count_r <= count_r - bdm_pkg::QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = slots_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

`default_nettype wire

// ===== rtl/bdm_back.sv =====
// Back end: turns queued windows into RGB pixels and holds them in the
// output register. Depends on bdm_pkg for the entry type and red position.
`default_nettype none

module bdm_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bdm_pkg::bdm_cfg_t   cfg,
  input  wire logic                head_valid,
  input  wire bdm_pkg::bdm_entry_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic                     out_end_of_row,
  output logic                     out_end_of_frame
);

  logic       out_valid_r, phase_r;
  logic [7:0] red_r, green_r, blue_r;
  logic       eor_r, eof_r;

  logic       slot_free, fire;
  logic [1:0] ri;
  logic [7:0] q [4];
  logic [8:0] gsum;

  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = head_valid && slot_free;
  // A row end stays at the head for its second pixel.
  assign pop       = fire && !(head.two && !phase_r);

  assign q[0] = head.q0;
  assign q[1] = head.q1;
  assign q[2] = head.q2;
  assign q[3] = head.q3;
  assign ri   = bdm_pkg::red_index(cfg.bayer_order, head.tp, head.lp);
  assign gsum = {1'b0, q[ri ^ 2'd1]} + {1'b0, q[ri ^ 2'd2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        phase_r     <= !pop;
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red_r   <= q[ri];
      green_r <= gsum[8:1];
      blue_r  <= q[~ri];
      eor_r   <= head.last || (head.two && phase_r);
      eof_r   <= head.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;

endmodule

`default_nettype wire

// ===== rtl/bayer_demosaic_2x2.sv =====
// 2x2 nearest Bayer demosaic, top level: configuration registers, front end,
// window queue and back end. Depends on bdm_pkg, bdm_front, bdm_queue, bdm_back.
//
// Usage:
//   in_*  : raw Bayer samples in raster order (in_op = 0) and, after the last
//           row of a frame, flush items (in_op = 1) that replay the final
//           output row one pixel each. Items of the wrong kind are dropped.
//   out_* : RGB pixels in raster order; end_of_row on the last pixel of each
//           output row, end_of_frame on the last replayed pixel.
//   cfg_* : cfg_we writes register cfg_index (0 bayer_order, 1 row_width,
//           2 frame_height) from cfg_data; write only while the block is idle.
// Path: window stage, window queue, then the output register drives out_*.
// Throughput: one item per clock while in_stall is low.
// A row end gives two pixels, which the back end emits from one queue entry.
// A four-entry window queue parts the two sides; in_stall rises once the
// queue and the window stage in flight would fill it, e.g. while out_stall
// holds the output register.
// Reset: counters clear to the start of a frame and registers take 0, 640,
// 480. The line stores are not cleared; every entry is written before it is
// read in a frame.
`default_nettype none

module bayer_demosaic_2x2 #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_op,
  input  wire logic [7:0]                      in_raw_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic                                 out_end_of_row,
  output logic                                 out_end_of_frame,
  input  wire logic                            cfg_we,
  input  wire logic [bdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bdm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0]  order_r, order_nxt;
  logic [11:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;

  bdm_pkg::bdm_cfg_t   cfg;
  bdm_pkg::bdm_entry_t push_entry, head;
  logic                push, pop, head_valid;
  logic [bdm_pkg::QCW-1:0] q_count;

  always_comb begin
    order_nxt  = order_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bdm_pkg::REG_BAYER_ORDER:  order_nxt  = cfg_data[1:0];
        bdm_pkg::REG_ROW_WIDTH:    width_nxt  = cfg_data[11:0];
        bdm_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= bdm_pkg::BAYER_ORDER_RST;
      width_r  <= bdm_pkg::ROW_WIDTH_RST;
      height_r <= bdm_pkg::FRAME_HEIGHT_RST;
    end else begin
      order_r  <= order_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign cfg.bayer_order  = order_r;
  assign cfg.row_width    = width_r;
  assign cfg.frame_height = height_r;

  bdm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_raw_pixel (in_raw_pixel),
    .in_stall     (in_stall),
    .q_count      (q_count),
    .push         (push),
    .push_entry   (push_entry)
  );

  bdm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  bdm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(q_count) < 32'(bdm_pkg::QDEPTH)))
    else $error("window queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("window queue read while empty");

  a_eof_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> out_end_of_row)
    else $error("end of frame without end of row");
`endif

endmodule

`default_nettype wire
